/* src/kgd_pkg.sv */
// Shared types and constants for the knob gesture decoder.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package kgd_pkg;

    localparam int PosWidth   = 32;
    localparam int EventWidth = 3;

    typedef enum logic [EventWidth-1:0] {
        EV_NEXT = 3'd0,
        EV_PREV = 3'd1,
        EV_UP   = 3'd2,
        EV_DOWN = 3'd3,
        EV_PLAY = 3'd4
    } event_t;

    typedef enum logic {
        REG_DEVICE_PRESENT = 1'b0,
        REG_FLIP_KNOB      = 1'b1
    } cfg_index_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic diff;
        logic plan;
        logic emit;
    } kgd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic poll_live;
        logic has_events;
        logic slot_free;
        logic final_event;
    } kgd_stat_t;

endpackage

/* src/kgd_if.sv */
// Valid/ready channel interfaces for polls and events.
// Depends on kgd_pkg for the payload widths.
`timescale 1ns / 1ps

interface kgd_in_if
    import kgd_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic                        int_pending;
    logic signed [PosWidth-1:0]  encoder_position;
    logic                        button_pressed;

    modport source (output valid, output int_pending, output encoder_position,
                    output button_pressed, input ready);
    modport sink   (input valid, input int_pending, input encoder_position,
                    input button_pressed, output ready);
endinterface

interface kgd_out_if
    import kgd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [EventWidth-1:0] event_res;
    logic                  last;

    modport source (output valid, output event_res, output last, input ready);
    modport sink   (input valid, input event_res, input last, output ready);
endinterface

/* src/knob_gesture_decoder.sv */
// Top level of the knob gesture decoder: controller, datapath and checks.
// Depends on kgd_pkg, kgd_if, kgd_ctrl and kgd_dp.
`timescale 1ns / 1ps

// Each poll beat carries an absolute encoder position, the push switch level
// and an interrupt-pending flag. A poll with no pending interrupt, or taken
// while device_present is 0, is absorbed with no event. A live poll is
// captured, then forms the 32-bit difference, then plans the events, and
// then sends one event beat per cycle from the output register while the
// event sink is ready: a track skip or up to MAX_VOLUME_STEPS volume steps,
// and a play/pause on a release without a turn while held. The next poll is
// taken while the last event still waits in the output register. The user
// must write the registers only while no poll is in progress; the block
// itself does not enforce it.
module knob_gesture_decoder
    import kgd_pkg::*;
#(
    parameter int MAX_VOLUME_STEPS = 63
)(
    input  logic        clk,
    input  logic        rst_n,
    kgd_in_if.sink      in_ch,
    kgd_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    kgd_cmd_t  cmd;
    kgd_stat_t stat;
    logic      in_ready;

    assign in_ch.ready = in_ready;

    kgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kgd_dp #(
        .MAX_VOLUME_STEPS (MAX_VOLUME_STEPS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .int_pending      (in_ch.int_pending),
        .encoder_position (in_ch.encoder_position),
        .button_pressed   (in_ch.button_pressed),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .event_res        (out_ch.event_res),
        .last             (out_ch.last)
    );

    // No planning or event emission may overlap with taking a new poll.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.emit && !cmd.plan && !cmd.diff)
        else $error("poll accepted while a previous poll is in progress");

    // Play/pause is always the final event of its poll.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.event_res == EV_PLAY) |-> out_ch.last)
        else $error("play/pause event not marked last");

    // Only defined event codes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.event_res <= EV_PLAY)
        else $error("undefined event code");

    // Planning always leads into emission.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.plan |=> cmd.emit)
        else $error("plan step not followed by emission");

endmodule

/* src/kgd_ctrl.sv */
// Sequencing state machine of the knob gesture decoder.
// Depends on kgd_pkg for the command and status structs.
`timescale 1ns / 1ps

module kgd_ctrl
    import kgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  kgd_stat_t stat,
    output kgd_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIFF,
        S_PLAN,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   accept;

    assign accept   = in_valid && in_ready_reg;
    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.capture = accept;
        cmd.diff    = (state_reg == S_DIFF);
        cmd.plan    = (state_reg == S_PLAN);
        cmd.emit    = (state_reg == S_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    // A poll without a pending interrupt or device is dropped here.
                    if (accept && stat.poll_live)
                    begin
                        state_reg    <= S_DIFF;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_PLAN;
                end
                S_PLAN:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!stat.has_events || (stat.slot_free && stat.final_event))
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

/* src/kgd_dp.sv */
// Datapath of the knob gesture decoder: poll state, turn planning and the
// output register. Depends on kgd_pkg.
`timescale 1ns / 1ps

module kgd_dp
    import kgd_pkg::*;
#(
    parameter int MAX_VOLUME_STEPS = 63
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic                       cfg_data,
    input  logic                       int_pending,
    input  logic signed [PosWidth-1:0] encoder_position,
    input  logic                       button_pressed,
    input  kgd_cmd_t                   cmd,
    output kgd_stat_t                  stat,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [EventWidth-1:0]      event_res,
    output logic                       last
);

    localparam int CntWidth = $clog2(MAX_VOLUME_STEPS + 1);
    localparam logic [PosWidth-1:0] MaxSteps = PosWidth'(MAX_VOLUME_STEPS);

    logic                  device_present_reg;
    logic                  flip_knob_reg;
    logic [PosWidth-1:0]   pos_reg;
    logic                  pressed_reg;
    logic [PosWidth-1:0]   delta_reg;
    logic [PosWidth-1:0]   last_position_reg;
    logic                  last_button_reg;
    logic                  rotated_reg;
    logic [CntWidth-1:0]   rem_reg;
    logic                  play_reg;
    event_t                turn_code_reg;
    logic                  out_valid_reg;
    event_t                out_event_reg;
    logic                  out_last_reg;

    logic                  neg;
    logic [PosWidth-1:0]   mag;
    logic                  turned;
    logic                  track;
    logic                  rotated_next;
    logic [CntWidth-1:0]   rem_next;
    event_t                turn_code_next;
    logic                  play_next;
    logic                  load;

    always_comb
    begin
        neg    = delta_reg[PosWidth-1];
        mag    = neg ? (PosWidth'(0) - delta_reg) : delta_reg;
        turned = (delta_reg != '0);
        track  = pressed_reg ^ flip_knob_reg;

        rem_next       = '0;
        turn_code_next = neg ? EV_DOWN : EV_UP;
        if (turned)
        begin
            if (track)
            begin
                rem_next       = CntWidth'(1);
                turn_code_next = neg ? EV_PREV : EV_NEXT;
            end
            else if (mag > MaxSteps)
            begin
                rem_next = CntWidth'(MAX_VOLUME_STEPS);
            end
            else
            begin
                rem_next = mag[CntWidth-1:0];
            end
        end

        // A turn while held marks the gesture; a fresh press starts it over.
        rotated_next = rotated_reg || (turned && pressed_reg);
        if (pressed_reg && !last_button_reg)
        begin
            rotated_next = 1'b0;
        end
        play_next = !pressed_reg && last_button_reg && !rotated_next;
    end

    assign load = cmd.emit && stat.has_events && stat.slot_free;

    always_comb
    begin
        stat             = '0;
        stat.poll_live   = int_pending && device_present_reg;
        stat.has_events  = (rem_reg != '0) || play_reg;
        stat.slot_free   = !out_valid_reg || out_ready;
        stat.final_event = ((rem_reg == CntWidth'(1)) && !play_reg)
                           || ((rem_reg == '0) && play_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_present_reg <= 1'b0;
            flip_knob_reg      <= 1'b0;
            last_position_reg  <= '0;
            last_button_reg    <= 1'b0;
            rotated_reg        <= 1'b0;
            rem_reg            <= '0;
            play_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    REG_DEVICE_PRESENT: device_present_reg <= cfg_data;
                    REG_FLIP_KNOB:      flip_knob_reg      <= cfg_data;
                    default:            device_present_reg <= device_present_reg;
                endcase
            end
            if (cmd.plan)
            begin
                last_position_reg <= pos_reg;
                last_button_reg   <= pressed_reg;
                rotated_reg       <= rotated_next;
                rem_reg           <= rem_next;
                play_reg          <= play_next;
            end
            else if (load)
            begin
                if (rem_reg != '0)
                begin
                    rem_reg <= rem_reg - CntWidth'(1);
                end
                else
                begin
                    play_reg <= 1'b0;
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg     <= encoder_position;
            pressed_reg <= button_pressed;
        end
        if (cmd.diff)
        begin
            delta_reg <= pos_reg - last_position_reg;
        end
        if (cmd.plan)
        begin
            turn_code_reg <= turn_code_next;
        end
        if (load)
        begin
            // Turn events go out before a play/pause event.
            out_event_reg <= (rem_reg != '0) ? turn_code_reg : EV_PLAY;
            out_last_reg  <= stat.final_event;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = out_event_reg;
    assign last      = out_last_reg;

endmodule

/* test/tb.sv */
// Self-checking testbench for knob_gesture_decoder: polls are sent on the input
// channel and every event beat is checked against a built-in decoder model.
// Depends on kgd_pkg, kgd_if and the knob_gesture_decoder RTL.
`timescale 1ns / 1ps

module tb
    import kgd_pkg::*;
;

    localparam int MaxVolumeSteps = 63;
    // DrainCycles outlasts the longest live poll when the event sink does not stall.
    localparam int DrainCycles    = MaxVolumeSteps + 16;

    typedef struct {
        event_t code;
        logic   last;
    } event_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_data;

    kgd_in_if  poll_ch ();
    kgd_out_if ev_ch ();

    knob_gesture_decoder #(
        .MAX_VOLUME_STEPS (MaxVolumeSteps)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (poll_ch),
        .out_ch    (ev_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Decoder model state and its copy of the registers.
    bit          knob_present;
    bit          knob_flip;
    logic [31:0] knob_pos;
    bit          knob_btn;
    bit          knob_turned_held;

    event_beat_t queued_events[$];
    int          mismatch_count;
    bit          idle_on;

    // Stimulus side memory for building well-formed knob sequences.
    logic [31:0] stim_pos;
    bit          stim_btn;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Works out the events one processed poll causes and queues them.
    function automatic void decode_poll(bit pend, logic [31:0] pos, bit pressed);
        logic [31:0] delta;
        logic [31:0] mag;
        bit          neg;
        event_t      codes[$];
        event_beat_t beat;
        if (!knob_present || !pend)
            return;
        delta = pos - knob_pos;
        if (delta != 32'd0)
        begin
            neg = delta[31];
            if (pressed ^ knob_flip)
            begin
                codes.push_back(neg ? EV_PREV : EV_NEXT);
            end
            else
            begin
                mag = neg ? (32'd0 - delta) : delta;
                if (mag > MaxVolumeSteps)
                    mag = MaxVolumeSteps;
                for (int i = 0; i < int'(mag); i++)
                    codes.push_back(neg ? EV_DOWN : EV_UP);
            end
            if (pressed)
                knob_turned_held = 1'b1;
            knob_pos = pos;
        end
        if (pressed && !knob_btn)
            knob_turned_held = 1'b0;
        else if (!pressed && knob_btn && !knob_turned_held)
            codes.push_back(EV_PLAY);
        knob_btn = pressed;
        for (int k = 0; k < codes.size(); k++)
        begin
            beat.code = codes[k];
            beat.last = (k == codes.size() - 1);
            queued_events.push_back(beat);
        end
    endfunction

    // Sink side: random stall bursts, while idle gaps are on, with long stretches of steady ready.
    initial
    begin
        ev_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                ev_ch.ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            ev_ch.ready = 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 120)) @(negedge clk);
            else
                repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : event_check
        event_beat_t want;
        if (rst_n && ev_ch.valid && ev_ch.ready)
        begin
            if (queued_events.size() == 0)
            begin
                $display("%0t: unexpected event beat: expected none, got code %0d last %0d",
                         $time, ev_ch.event_res, ev_ch.last);
                mismatch_count++;
            end
            else
            begin
                want = queued_events.pop_front();
                if (ev_ch.event_res !== want.code || ev_ch.last !== want.last)
                begin
                    $display("%0t: event mismatch: expected code %0d last %0d,",
                             $time, want.code, want.last,
                             " got code %0d last %0d", ev_ch.event_res, ev_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge, with valid high
    // unless an idle gap was inserted.
    task automatic send_poll(bit pend, logic [31:0] pos, bit pressed);
        poll_ch.valid            = 1'b1;
        poll_ch.int_pending      = pend;
        poll_ch.encoder_position = pos;
        poll_ch.button_pressed   = pressed;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        decode_poll(pend, pos, pressed);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            poll_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    task automatic drain_events();
        poll_ch.valid = 1'b0;
        while (queued_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, bit val);
        drain_events();
        // Ignored polls leave nothing to wait for, so give the block time to settle.
        repeat (DrainCycles) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_DEVICE_PRESENT)
            knob_present = val;
        else
            knob_flip = val;
    endtask

    task automatic send_random_poll(output bit live);
        int          r;
        int          step;
        bit          pend;
        logic [31:0] pos;
        pend = ($urandom_range(0, 99) >= 10);
        if ($urandom_range(0, 3) == 0)
            stim_btn = !stim_btn;
        r = $urandom_range(0, 99);
        if (r < 15)
            step = 0;
        else if (r < 80)
            step = int'($urandom_range(0, 140)) - 70;
        else
            step = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(60, 400));
        if (r >= 94)
            pos = $urandom;
        else
            pos = stim_pos + step;
        stim_pos = pos;
        send_poll(pend, pos, stim_btn);
        live = pend && knob_present;
    endtask

    task automatic test_ignored_polls();
        send_poll(1'b1, 32'd5, 1'b0);
        send_poll(1'b0, 32'd9, 1'b1);
        write_reg(REG_DEVICE_PRESENT, 1'b1);
        write_reg(REG_FLIP_KNOB, 1'b0);
        send_poll(1'b0, 32'd1000, 1'b1);
    endtask

    task automatic test_volume_turns();
        send_poll(1'b1, 32'd1, 1'b0);
        send_poll(1'b1, 32'd0, 1'b0);
        send_poll(1'b1, 32'd0, 1'b0);
        send_poll(1'b1, 32'd63, 1'b0);
        send_poll(1'b1, 32'd127, 1'b0);
        send_poll(1'b1, 32'h7FFF_FFFF, 1'b0);
        // Wraps past the top of the range: a one-step turn.
        send_poll(1'b1, 32'h8000_0000, 1'b0);
        // Difference of exactly the most negative value.
        send_poll(1'b1, 32'h0000_0000, 1'b0);
        send_poll(1'b1, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_track_skip_and_play();
        send_poll(1'b1, 32'hFFFF_FFFF, 1'b1);
        send_poll(1'b1, 32'hFFFF_FFFF, 1'b0);
        send_poll(1'b1, 32'hFFFF_FFFF, 1'b1);
        send_poll(1'b1, 32'd4, 1'b1);
        send_poll(1'b1, 32'd1, 1'b1);
        send_poll(1'b1, 32'd1, 1'b0);
        // The turn marks the knob as turned, then the new press clears it.
        send_poll(1'b1, 32'd3, 1'b1);
        // Volume steps come first, then play/pause.
        send_poll(1'b1, 32'd7, 1'b0);
    endtask

    task automatic test_flipped_knob();
        write_reg(REG_FLIP_KNOB, 1'b1);
        send_poll(1'b1, 32'd10, 1'b0);
        send_poll(1'b1, 32'd3, 1'b1);
        send_poll(1'b1, 32'd3, 1'b0);
        stim_pos = 32'd3;
        stim_btn = 1'b0;
    endtask

    task automatic test_random_polls();
        int n;
        bit live;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_FLIP_KNOB, phase[0]);
            n = 0;
            while (n < 48)
            begin
                if (phase == 1 && n == 25)
                    drain_events();
                send_random_poll(live);
                if (live)
                    n++;
            end
            if (phase == 1)
            begin
                write_reg(REG_DEVICE_PRESENT, 1'b0);
                repeat (10) send_random_poll(live);
                write_reg(REG_DEVICE_PRESENT, 1'b1);
            end
        end
    endtask

    task automatic test_steady_polls();
        int n;
        bit live;
        write_reg(REG_FLIP_KNOB, 1'b0);
        idle_on = 1'b0;
        n = 0;
        while (n < 30)
        begin
            send_random_poll(live);
            if (live)
                n++;
        end
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = REG_DEVICE_PRESENT;
        cfg_data                 = 1'b0;
        poll_ch.valid            = 1'b0;
        poll_ch.int_pending      = 1'b0;
        poll_ch.encoder_position = '0;
        poll_ch.button_pressed   = 1'b0;
        knob_present             = 1'b0;
        knob_flip                = 1'b0;
        knob_pos                 = '0;
        knob_btn                 = 1'b0;
        knob_turned_held         = 1'b0;
        mismatch_count           = 0;
        idle_on                  = 1'b1;
        stim_pos                 = '0;
        stim_btn                 = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_ignored_polls();
        test_volume_turns();
        test_track_skip_and_play();
        test_flipped_knob();
        test_random_polls();
        test_steady_polls();

        drain_events();
        repeat (DrainCycles) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
